// ===== hw/rtl/tkpress_pkg.sv =====
// Shared types and constants for the three-key press classifier.
// No dependencies; imported by the lane, merge and top-level modules.
package tkpress_pkg;

    localparam int CNT_W     = 16;  // hold counter width
    localparam int CODE_W    = 8;   // press code width
    localparam int LEVEL_W   = 3;   // key level field width
    localparam int CFG_IDX_W = 2;   // configuration register index width
    localparam int CFG_DW    = 16;  // configuration write data width

    localparam logic [CFG_IDX_W-1:0] REG_LONG_THR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] LONG_THR_RST  = CNT_W'(100);
    localparam logic [CNT_W-1:0] SHORT_THR_RST = CNT_W'(2);

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // What one lane found on the current scan tick.
    typedef struct packed {
        logic set_long;
        logic set_short;
    } lane_hit_t;

endpackage

// ===== hw/rtl/three_key_short_long_press_classifier.sv =====
// Top level of the short/long press classifier: config registers, key lanes,
// merge stage and a two-entry output buffer. Depends on tkpress_pkg,
// tkpress_lane and tkpress_merge.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  s_      | in        | s_valid / s_ready   | s_command, s_key_levels, s_new_press
//  m_      | out       | m_valid / m_ready   | m_press_code
//  cfg_    | in        | cfg_wen (no wait)   | cfg_index, cfg_wdata
//
// One request per clock while s_ready is high; its result is registered into the output buffer.
// The lane counters update and compare in the same cycle, so the only loop
// is the counter/latched-code register update.
// A two-entry output buffer lets one more request in while a result is stalled;
// s_ready drops only when both entries are full.
// Synchronous active-low reset clears counters, code and buffer valid flags and loads default thresholds.
module three_key_short_long_press_classifier
    import tkpress_pkg::*;
#(
    parameter int NUM_KEYS = 3
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [LEVEL_W-1:0]   s_key_levels,
    input  logic [CODE_W-1:0]    s_new_press,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CODE_W-1:0]    m_press_code,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wdata
);

    logic [CNT_W-1:0]  long_thr_reg;
    logic [CNT_W-1:0]  short_thr_reg;
    logic              push;
    logic              pop;
    logic              scan_en;
    logic [CODE_W-1:0] code_next;
    lane_hit_t         hits [NUM_KEYS];

    logic              head_valid_reg;
    logic              skid_valid_reg;
    logic [CODE_W-1:0] head_reg;
    logic [CODE_W-1:0] skid_reg;

    assign s_ready      = !skid_valid_reg;
    assign push         = s_valid && s_ready;
    assign pop          = head_valid_reg && m_ready;
    assign scan_en      = push && (s_command == CMD_SCAN);
    assign m_valid      = head_valid_reg;
    assign m_press_code = head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_thr_reg  <= LONG_THR_RST;
            short_thr_reg <= SHORT_THR_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_LONG_THR:  long_thr_reg  <= CNT_W'(cfg_wdata);
                REG_SHORT_THR: short_thr_reg <= CNT_W'(cfg_wdata);
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic pressed;
        // Keys without a level bit read as held.
        if (k < LEVEL_W) begin : g_pin
            assign pressed = !s_key_levels[k];
        end else begin : g_nopin
            assign pressed = 1'b1;
        end

        tkpress_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .scan_en   (scan_en),
            .pressed   (pressed),
            .long_thr  (long_thr_reg),
            .short_thr (short_thr_reg),
            .hit       (hits[k])
        );
    end

    tkpress_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_en    (push),
        .command   (s_command),
        .new_press (s_new_press),
        .hits      (hits),
        .code_next (code_next)
    );

    // Output buffer: head drives the port, skid holds one extra result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop && push) begin
                head_valid_reg <= 1'b1;
            end else if (pop) begin
                head_valid_reg <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                if (head_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    head_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && push) begin
            head_reg <= code_next;
        end else if (pop) begin
            head_reg <= skid_reg;
        end else if (push) begin
            if (head_valid_reg) begin
                skid_reg <= code_next;
            end else begin
                head_reg <= code_next;
            end
        end
    end

`ifndef ASSERT_OFF
    // The skid entry is never occupied without a head entry.
    a_skid_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid with empty head");
    // Backpressure on the input only while a result is waiting.
    a_ready_low_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");
    // Popping with the skid full moves the buffered result forward.
    a_skid_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && skid_valid_reg |=> m_valid && m_press_code == $past(skid_reg))
        else $error("skid result lost on pop");
`endif

endmodule

// ===== hw/rtl/tkpress_lane.sv =====
// One key lane: saturating hold counter and threshold compares.
// Depends on tkpress_pkg.
module tkpress_lane
    import tkpress_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             scan_en,
    input  logic             pressed,
    input  logic [CNT_W-1:0] long_thr,
    input  logic [CNT_W-1:0] short_thr,
    output lane_hit_t        hit
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;

    // Stop at full scale instead of wrapping.
    assign cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + CNT_W'(1);
    assign cnt_next = pressed ? cnt_inc : '0;

    always_comb begin
        hit = '0;
        if (pressed) begin
            hit.set_long = (cnt_inc > long_thr);
        end else begin
            hit.set_short = (cnt_reg < long_thr) && (cnt_reg > short_thr);
            hit.set_long  = (cnt_reg > long_thr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (scan_en) begin
            cnt_reg <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    // A released key always leaves its counter at zero.
    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_en && !pressed |=> cnt_reg == '0)
        else $error("lane counter not cleared on release");
    // A held key never loses count.
    a_hold_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_en && pressed |=> cnt_reg >= $past(cnt_reg) && cnt_reg != '0)
        else $error("lane counter dropped while held");
    // Short and long never fire together.
    a_hit_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(hit.set_long && hit.set_short))
        else $error("lane reports short and long at once");
`endif

endmodule

// ===== hw/rtl/tkpress_merge.sv =====
// Merging stage: takes the set value or combines lane hits in key order, and holds the latched code.
// Depends on tkpress_pkg.
module tkpress_merge
    import tkpress_pkg::*;
#(
    parameter int NUM_KEYS = 3
)(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_en,
    input  logic              command,
    input  logic [CODE_W-1:0] new_press,
    input  lane_hit_t         hits [NUM_KEYS],
    output logic [CODE_W-1:0] code_next
);

    logic [CODE_W-1:0] latched_reg;

    // Later keys take priority, so walk upward and overwrite.
    always_comb begin
        code_next = latched_reg;
        if (command == CMD_SET) begin
            code_next = new_press;
        end else begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (hits[i].set_long) begin
                    code_next = CODE_W'(2 * i + 2);
                end else if (hits[i].set_short) begin
                    code_next = CODE_W'(2 * i + 1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_reg <= '0;
        end else if (req_en) begin
            latched_reg <= code_next;
        end
    end

endmodule

// ===== sim/tb_three_key_short_long_press_classifier.sv =====
// Self-checking testbench for the three-key short/long press classifier.
// Drives scan ticks and set requests, predicts each press code and checks it.
// Depends on tkpress_pkg and three_key_short_long_press_classifier.
`timescale 1ns / 100ps

module tb_three_key_short_long_press_classifier;
    import tkpress_pkg::*;

    localparam int KEYS           = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BACKLOG_AT     = 300;  // results seen before the long receiver hold
    localparam int BACKLOG_CYCLES = 100;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    localparam logic [LEVEL_W-1:0] KEYS_UP   = '1;
    localparam logic [LEVEL_W-1:0] KEYS_DOWN = '0;

    typedef struct packed {
        logic               cmd;
        logic [LEVEL_W-1:0] levels;
        logic [CODE_W-1:0]  set_value;
    } press_req_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic                 s_command    = CMD_SCAN;
    logic [LEVEL_W-1:0]   s_key_levels = KEYS_UP;
    logic [CODE_W-1:0]    s_new_press  = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [CODE_W-1:0]    m_press_code;
    logic                 cfg_wen      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_DW-1:0]    cfg_wdata    = '0;

    // predictor state
    logic [CNT_W-1:0]  thr_long  = LONG_THR_RST;
    logic [CNT_W-1:0]  thr_short = SHORT_THR_RST;
    logic [CNT_W-1:0]  key_hold [KEYS];
    logic [CODE_W-1:0] press_latch = '0;

    press_req_t        req_pending [$];
    logic [CODE_W-1:0] codes_due [$];

    int   items_queued   = 0;
    int   items_accepted = 0;
    int   codes_checked  = 0;
    int   err_count      = 0;
    int   stuck_cycles   = 0;
    logic req_taken      = 1'b0;

    three_key_short_long_press_classifier #(
        .NUM_KEYS(KEYS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_key_levels(s_key_levels),
        .s_new_press (s_new_press),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_press_code(m_press_code),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the hold counters for a scan request (or take a set value) and return the latched code.
    function automatic logic [CODE_W-1:0] classify_request(logic cmd,
                                                           logic [LEVEL_W-1:0] lv,
                                                           logic [CODE_W-1:0] value);
        int               k;
        logic             held;
        logic [CNT_W-1:0] n;
        if (cmd == CMD_SET) begin
            press_latch = value;
        end else begin
            for (k = 0; k < KEYS; k++) begin
                held = (k < LEVEL_W) ? !lv[k] : 1'b1;
                n = key_hold[k];
                if (held) begin
                    if (n != '1) n = n + 1'b1;
                    key_hold[k] = n;
                    if (n > thr_long) press_latch = CODE_W'(2 * k + 2);
                end else begin
                    if (n < thr_long && n > thr_short) press_latch = CODE_W'(2 * k + 1);
                    else if (n > thr_long) press_latch = CODE_W'(2 * k + 2);
                    key_hold[k] = '0;
                end
            end
        end
        return press_latch;
    endfunction

    function automatic void push_req(logic cmd, logic [LEVEL_W-1:0] lv,
                                     logic [CODE_W-1:0] value);
        press_req_t r;
        r.cmd       = cmd;
        r.levels    = lv;
        r.set_value = value;
        req_pending.push_back(r);
        items_queued++;
    endfunction

    function automatic void hold_keys(logic [LEVEL_W-1:0] lv, int ticks);
        repeat (ticks) push_req(CMD_SCAN, lv, CODE_W'($urandom));
    endfunction

    // Hold lengths clustered around the thresholds so every release rule fires.
    function automatic int pick_hold_len();
        int len;
        case ($urandom_range(0, 5))
            0:       len = int'($urandom_range(1, 4));
            1:       len = int'(thr_short) + int'($urandom_range(0, 2));
            2, 3:    len = int'(thr_long) - 1 + int'($urandom_range(0, 2));
            4:       len = int'(thr_long);
            default: len = int'($urandom_range(1, 40));
        endcase
        if (len < 1 || len > 200) len = int'($urandom_range(1, 40));
        return len;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
        @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wen = 1'b0;
        if (idx == REG_LONG_THR) thr_long = data;
        else if (idx == REG_SHORT_THR) thr_short = data;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (items_accepted != items_queued || codes_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Request driver: bursts of random length, random gaps between them.
    always @(negedge aclk) begin : drive_requests
        press_req_t nxt;
        int         burst_left;
        int         gap_left;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else if (!s_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (req_pending.size() > 0) begin
                nxt = req_pending.pop_front();
                s_valid      <= 1'b1;
                s_command    <= nxt.cmd;
                s_key_levels <= nxt.levels;
                s_new_press  <= nxt.set_value;
                if (burst_left <= 1) begin
                    burst_left = int'($urandom_range(1, 40));
                    gap_left   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8)) : 0;
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall pattern in segments, plus one long hold to back up the block.
    always @(negedge aclk) begin : drive_ready
        int   stall_mode;
        int   stall_seg;
        int   backlog_left;
        logic backlog_done;
        if (!aresetn) begin
            m_ready      <= 1'b0;
            stall_mode   = 0;
            stall_seg    = 0;
            backlog_left = 0;
            backlog_done = 1'b0;
        end else if (backlog_left > 0) begin
            backlog_left--;
            m_ready <= 1'b0;
        end else if (!backlog_done && codes_checked >= BACKLOG_AT) begin
            backlog_done = 1'b1;
            backlog_left = BACKLOG_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (stall_seg == 0) begin
                stall_mode = int'($urandom_range(0, 3));
                stall_seg  = int'($urandom_range(8, 64));
            end else begin
                stall_seg--;
            end
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 1);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= !m_ready;
            endcase
        end
    end

    // Predict on every accepted request, check every accepted result.
    always @(posedge aclk) begin : check_codes
        logic [CODE_W-1:0] want;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                codes_due.push_back(classify_request(s_command, s_key_levels, s_new_press));
                items_accepted <= items_accepted + 1;
            end
            if (m_valid && m_ready) begin
                codes_checked <= codes_checked + 1;
                if (codes_due.size() == 0) begin
                    $error("unexpected result: press_code %0d", m_press_code);
                    err_count++;
                end else begin
                    want = codes_due.pop_front();
                    if (m_press_code !== want) begin
                        $error("press_code mismatch: expected %0d, actual %0d",
                               want, m_press_code);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready)) stuck_cycles++;
        else stuck_cycles = 0;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int                 ph;
        int                 k;
        int                 roll;
        int                 hold_left [KEYS];
        int                 rel_left [KEYS];
        logic [LEVEL_W-1:0] lv;
        logic [CNT_W-1:0]   lt;
        logic [CNT_W-1:0]   st;

        for (k = 0; k < KEYS; k++) key_hold[k] = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // reset thresholds: idle, both set extremes, a short press of key 3
        push_req(CMD_SCAN, KEYS_UP, '0);
        push_req(CMD_SET, KEYS_DOWN, '1);
        push_req(CMD_SET, KEYS_UP, '0);
        hold_keys(3'b011, 3);
        hold_keys(KEYS_UP, 1);
        wait_drained();

        cfg_write(REG_SPARE_A, '1);
        cfg_write(REG_SPARE_B, '0);
        cfg_write(REG_LONG_THR, CFG_DW'(4));
        cfg_write(REG_SHORT_THR, CFG_DW'(1));
        hold_keys(3'b110, 3);           // key 1 short
        hold_keys(KEYS_UP, 1);
        push_req(CMD_SET, KEYS_UP, '0);
        hold_keys(3'b110, 4);           // release right at the long threshold: no code
        hold_keys(KEYS_UP, 1);
        hold_keys(3'b101, 2);
        push_req(CMD_SET, 3'b101, 8'hA5); // set mid-hold leaves the counter alone
        hold_keys(3'b101, 3);           // key 2 goes long while held
        hold_keys(KEYS_UP, 1);
        hold_keys(KEYS_DOWN, 5);        // all keys long: key 3 wins
        hold_keys(KEYS_UP, 1);

        // random press sequences over several threshold settings
        for (ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin lt = 16'd4;     st = 16'd1;     end
                1: begin lt = 16'd0;     st = 16'd0;     end
                2: begin lt = 16'hFFFF;  st = 16'hFFFF;  end
                3: begin lt = 16'd3;     st = 16'd7;     end  // short above long
                4: begin lt = 16'hFFFF;  st = 16'd2;     end
                5: begin lt = 16'd6;     st = 16'd6;     end
                6: begin lt = 16'd12;    st = 16'd0;     end
                7: begin lt = 16'd1;     st = 16'hFFFF;  end
                default: begin
                    lt = CNT_W'($urandom_range(0, 24));
                    st = CNT_W'($urandom_range(0, 24));
                end
            endcase
            wait_drained();
            cfg_write(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                      CFG_DW'($urandom));
            cfg_write(REG_SHORT_THR, st);
            cfg_write(REG_LONG_THR, lt);
            for (k = 0; k < KEYS; k++) begin
                hold_left[k] = 0;
                rel_left[k]  = 0;
            end
            repeat (200) begin
                roll = int'($urandom_range(0, 99));
                if (roll < 8) begin
                    push_req(CMD_SET, LEVEL_W'($urandom), CODE_W'($urandom));
                end else if (roll < 13) begin
                    push_req(CMD_SCAN, LEVEL_W'($urandom), CODE_W'($urandom));
                end else begin
                    for (k = 0; k < KEYS; k++) begin
                        if (hold_left[k] == 0 && rel_left[k] == 0) begin
                            hold_left[k] = ($urandom_range(0, 3) == 0) ? 0 : pick_hold_len();
                            rel_left[k]  = int'($urandom_range(1, 4));
                        end
                        if (hold_left[k] > 0) begin
                            lv[k] = 1'b0;
                            hold_left[k]--;
                        end else begin
                            lv[k] = 1'b1;
                            rel_left[k]--;
                        end
                    end
                    push_req(CMD_SCAN, lv, CODE_W'($urandom));
                end
            end
            hold_keys(KEYS_UP, 1);
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tkpress_pkg.sv
hw/rtl/tkpress_lane.sv
hw/rtl/tkpress_merge.sv
hw/rtl/three_key_short_long_press_classifier.sv
sim/tb_three_key_short_long_press_classifier.sv
